// ----- rtl/core/s5hs_pkg.sv -----
// ----------------------------------------------------------------------------
// s5hs_pkg
// Shared types, codes and helpers of the SOCKS5 server handshake parser.
// ----------------------------------------------------------------------------
package s5hs_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_CONNECT = 1'b1;

  localparam logic [2:0] KIND_REPLY   = 3'd0;
  localparam logic [2:0] KIND_ADDR    = 3'd1;
  localparam logic [2:0] KIND_PORT    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_CLOSE   = 3'd4;

  localparam logic [1:0] DT_DOMAIN = 2'd0;
  localparam logic [1:0] DT_IPV4   = 2'd1;
  localparam logic [1:0] DT_IPV6   = 2'd2;

  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] METH_NOAUTH   = 8'h00;
  localparam logic [7:0] METH_NONE     = 8'hFF;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] ERR_GENERAL   = 8'h01;
  localparam logic [7:0] ERR_CMD       = 8'h07;
  localparam logic [7:0] ERR_ATYP      = 8'h08;

  localparam logic [4:0] LEN_METH_OK   = 5'd2;
  localparam logic [4:0] LEN_METH_FAIL = 5'd3;
  localparam logic [4:0] LEN_ERROR     = 5'd11;
  localparam logic [4:0] LEN_OK_V4     = 5'd10;
  localparam logic [4:0] LEN_OK_V6     = 5'd22;

  typedef enum logic [2:0] {
    JOB_SINGLE,
    JOB_METH_OK,
    JOB_METH_FAIL,
    JOB_ERROR,
    JOB_SUCCESS
  } job_e;

  typedef struct packed {
    job_e        op;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [1:0]  dtype;
    logic        v6;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] port;
  } job_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] dtype;
    logic       last;
  } res_t;

  function automatic logic [4:0] job_len(job_t j);
    logic [4:0] len;
    unique case (j.op)
      JOB_SINGLE:    len = 5'd1;
      JOB_METH_OK:   len = LEN_METH_OK;
      JOB_METH_FAIL: len = LEN_METH_FAIL;
      JOB_ERROR:     len = LEN_ERROR;
      JOB_SUCCESS:   len = j.v6 ? LEN_OK_V6 : LEN_OK_V4;
      default:       len = 5'd1;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/s5hs_front.sv -----
// ----------------------------------------------------------------------------
// s5hs_front
// Handshake state machine: takes each input and emits one reply job or none.
// ----------------------------------------------------------------------------
module s5hs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           opcode_i,
  input  logic [7:0]     data_byte_i,
  input  logic [7:0]     connect_status_i,
  input  logic           bound_is_v6_i,
  input  logic [63:0]    bound_addr_hi_i,
  input  logic [63:0]    bound_addr_lo_i,
  input  logic [15:0]    bound_port_i,
  output logic           job_vld_o,
  output s5hs_pkg::job_t job_o
);
  import s5hs_pkg::*;

  localparam logic [3:0] PH_GVER       = 4'd0;
  localparam logic [3:0] PH_GNMETH     = 4'd1;
  localparam logic [3:0] PH_GMETH      = 4'd2;
  localparam logic [3:0] PH_RHDR       = 4'd3;
  localparam logic [3:0] PH_DLEN       = 4'd4;
  localparam logic [3:0] PH_ADDR       = 4'd5;
  localparam logic [3:0] PH_PORT       = 4'd6;
  localparam logic [3:0] PH_CONNECTING = 4'd7;
  localparam logic [3:0] PH_CONNECTED  = 4'd8;
  localparam logic [3:0] PH_CLOSED     = 4'd9;

  logic [3:0] phase_q, phase_d;
  logic [1:0] bcnt_q, bcnt_d;
  logic [7:0] rem_q, rem_d;
  logic       noauth_q, noauth_d;
  logic [1:0] akind_q, akind_d;
  logic [7:0] perr_q, perr_d;
  logic [7:0] rem_dec;
  logic       seen;
  logic       vld;
  job_t       job;

  assign rem_dec = rem_q - 8'd1;
  assign seen    = noauth_q | (data_byte_i == METH_NOAUTH);

  always_comb begin
    phase_d = phase_q;
    bcnt_d  = bcnt_q;
    rem_d   = rem_q;
    noauth_d = noauth_q;
    akind_d = akind_q;
    perr_d  = perr_q;
    vld     = 1'b0;
    job     = '0;
    job.op  = JOB_SINGLE;
    job.hi  = bound_addr_hi_i;
    job.lo  = bound_addr_lo_i;
    job.port = bound_port_i;
    job.v6  = bound_is_v6_i;
    if (opcode_i == OP_CONNECT) begin
      if (phase_q == PH_CONNECTING) begin
        vld = 1'b1;
        if (connect_status_i != 8'd0) begin
          job.op   = JOB_ERROR;
          job.data = connect_status_i;
          phase_d  = PH_CLOSED;
        end else begin
          job.op  = JOB_SUCCESS;
          phase_d = PH_CONNECTED;
        end
      end
    end else begin
      unique case (phase_q)
        PH_GVER: begin
          if (data_byte_i != SOCKS_VER) begin
            vld = 1'b1;
            job.kind = KIND_CLOSE;
            phase_d = PH_CLOSED;
          end else begin
            phase_d = PH_GNMETH;
          end
        end
        PH_GNMETH: begin
          rem_d = data_byte_i;
          noauth_d = 1'b0;
          if (data_byte_i == 8'd0) begin
            vld = 1'b1;
            job.op = JOB_METH_FAIL;
            phase_d = PH_CLOSED;
          end else begin
            phase_d = PH_GMETH;
          end
        end
        PH_GMETH: begin
          noauth_d = seen;
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            vld = 1'b1;
            if (seen) begin
              job.op  = JOB_METH_OK;
              phase_d = PH_RHDR;
              bcnt_d  = 2'd0;
              perr_d  = 8'd0;
            end else begin
              job.op  = JOB_METH_FAIL;
              phase_d = PH_CLOSED;
            end
          end
        end
        PH_RHDR: begin
          unique case (bcnt_q)
            2'd0: begin
              perr_d = (data_byte_i != SOCKS_VER) ? ERR_GENERAL : 8'd0;
              bcnt_d = 2'd1;
            end
            2'd1: begin
              if (perr_q == 8'd0 && data_byte_i != CMD_CONNECT) perr_d = ERR_CMD;
              bcnt_d = 2'd2;
            end
            2'd2: begin
              if (data_byte_i != 8'd0) perr_d = ERR_GENERAL;
              bcnt_d = 2'd3;
            end
            default: begin
              bcnt_d = 2'd0;
              if (perr_q != 8'd0) begin
                vld = 1'b1;
                job.op = JOB_ERROR;
                job.data = perr_q;
                phase_d = PH_CLOSED;
              end else if (data_byte_i == ATYP_IPV4) begin
                akind_d = DT_IPV4;
                rem_d = 8'd4;
                phase_d = PH_ADDR;
              end else if (data_byte_i == ATYP_IPV6) begin
                akind_d = DT_IPV6;
                rem_d = 8'd16;
                phase_d = PH_ADDR;
              end else if (data_byte_i == ATYP_DOMAIN) begin
                akind_d = DT_DOMAIN;
                phase_d = PH_DLEN;
              end else begin
                vld = 1'b1;
                job.op = JOB_ERROR;
                job.data = ERR_ATYP;
                phase_d = PH_CLOSED;
              end
            end
          endcase
        end
        PH_DLEN: begin
          if (data_byte_i == 8'd0) begin
            rem_d = 8'd2;
            phase_d = PH_PORT;
          end else begin
            rem_d = data_byte_i;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          vld = 1'b1;
          job.kind = KIND_ADDR;
          job.data = data_byte_i;
          job.dtype = akind_q;
          rem_d = rem_dec;
          if (rem_dec == 8'd0) begin
            rem_d = 8'd2;
            phase_d = PH_PORT;
          end
        end
        PH_PORT: begin
          vld = 1'b1;
          job.kind = KIND_PORT;
          job.data = data_byte_i;
          job.dtype = akind_q;
          rem_d = rem_dec;
          if (rem_dec == 8'd0) phase_d = PH_CONNECTING;
        end
        PH_CONNECTING, PH_CONNECTED: begin
          vld = 1'b1;
          job.kind = KIND_PAYLOAD;
          job.data = data_byte_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign job_vld_o = accept_i & vld;
  assign job_o     = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_GVER;
      bcnt_q   <= 2'd0;
      rem_q    <= 8'd0;
      noauth_q <= 1'b0;
      akind_q  <= 2'd0;
      perr_q   <= 8'd0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      bcnt_q   <= bcnt_d;
      rem_q    <= rem_d;
      noauth_q <= noauth_d;
      akind_q  <= akind_d;
      perr_q   <= perr_d;
    end
  end

endmodule

// ----- rtl/core/s5hs_fifo.sv -----
// ----------------------------------------------------------------------------
// s5hs_fifo
// Short job queue between the state machine and the reply serializer.
// ----------------------------------------------------------------------------
module s5hs_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  s5hs_pkg::job_t wr_job_i,
  input  logic           rd_i,
  output s5hs_pkg::job_t rd_job_o,
  output logic           full_o,
  output logic           empty_o
);
  import s5hs_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_wr, do_rd;

  assign full_o   = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i & ~full_o;
  assign do_rd    = rd_i & ~empty_o;
  assign rd_job_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + QPTR_W'(1);
      if (do_rd) rptr_q <= rptr_q + QPTR_W'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/s5hs_back.sv -----
// ----------------------------------------------------------------------------
// s5hs_back
// Reply serializer: expands each job into result bytes, one per cycle while results are popped.
// ----------------------------------------------------------------------------
module s5hs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  s5hs_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output s5hs_pkg::res_t res_o
);
  import s5hs_pkg::*;

  logic [4:0]       idx_q;
  logic             vld_q;
  res_t             res_q;
  res_t             res;
  logic [4:0]       len;
  logic             take;
  logic [31:0][7:0] sbytes;

  assign len  = job_len(job_i);
  assign take = ~job_empty_i & (~vld_q | pop_i);

  always_comb begin
    sbytes    = '0;
    sbytes[0] = SOCKS_VER;
    sbytes[3] = job_i.v6 ? ATYP_IPV6 : ATYP_IPV4;
    if (job_i.v6) begin
      for (int i = 0; i < 8; i++) begin
        sbytes[4 + i]  = job_i.hi[8*(7-i) +: 8];
        sbytes[12 + i] = job_i.lo[8*(7-i) +: 8];
      end
      sbytes[20] = job_i.port[15:8];
      sbytes[21] = job_i.port[7:0];
    end else begin
      for (int i = 0; i < 4; i++) begin
        sbytes[4 + i] = job_i.lo[8*(3-i) +: 8];
      end
      sbytes[8] = job_i.port[15:8];
      sbytes[9] = job_i.port[7:0];
    end
  end

  always_comb begin
    res       = '0;
    res.kind  = KIND_REPLY;
    res.last  = (idx_q == len - 5'd1);
    unique case (job_i.op)
      JOB_SINGLE: begin
        res.kind  = job_i.kind;
        res.data  = job_i.data;
        res.dtype = job_i.dtype;
      end
      JOB_METH_OK: begin
        res.data = (idx_q == 5'd0) ? SOCKS_VER : METH_NOAUTH;
      end
      JOB_METH_FAIL: begin
        if (idx_q == 5'd0) res.data = SOCKS_VER;
        else if (idx_q == 5'd1) res.data = METH_NONE;
        else res.kind = KIND_CLOSE;
      end
      JOB_ERROR: begin
        if (idx_q == 5'd0) res.data = SOCKS_VER;
        else if (idx_q == 5'd1) res.data = job_i.data;
        else if (idx_q == 5'd3) res.data = ATYP_IPV4;
        else if (idx_q == LEN_ERROR - 5'd1) res.kind = KIND_CLOSE;
      end
      JOB_SUCCESS: begin
        res.data = sbytes[idx_q];
      end
      default: begin
      end
    endcase
  end

  assign job_pop_o = take & res.last;
  assign empty_o   = ~vld_q;
  assign res_o     = res_q;

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 5'd0;
    end else begin
      if (take) begin
        vld_q <= 1'b1;
        idx_q <= res.last ? 5'd0 : idx_q + 5'd1;
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/socks5_handshake_parser_top.sv -----
// ----------------------------------------------------------------------------
// socks5_handshake_parser_top
// Server side SOCKS5 handshake: greeting, request checks and connect reply.
// ----------------------------------------------------------------------------
// One input item is accepted per cycle while full is low. The state machine
// classifies each item in the cycle it arrives and queues at most one reply
// job in a four-entry queue; the serializer behind it sends one result per
// cycle while results are popped, and an item yields one result for address,
// port and payload bytes, 11 for an error reply and 22 for an IPv6 success
// reply. Input stalls only when the queue fills behind a long reply or a
// stalled consumer.
module socks5_handshake_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  connect_status_i,
  input  logic        bound_is_v6_i,
  input  logic [63:0] bound_addr_hi_i,
  input  logic [63:0] bound_addr_lo_i,
  input  logic [15:0] bound_port_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  dest_type_o,
  output logic        last_o
);
  import s5hs_pkg::*;

  logic accept;
  logic job_vld;
  job_t job_in;
  job_t job_head;
  logic job_empty;
  logic job_pop;
  res_t res;

  assign accept = push & ~full;

  s5hs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .connect_status_i (connect_status_i),
    .bound_is_v6_i    (bound_is_v6_i),
    .bound_addr_hi_i  (bound_addr_hi_i),
    .bound_addr_lo_i  (bound_addr_lo_i),
    .bound_port_i     (bound_port_i),
    .job_vld_o        (job_vld),
    .job_o            (job_in)
  );

  s5hs_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (job_vld),
    .wr_job_i (job_in),
    .rd_i     (job_pop),
    .rd_job_o (job_head),
    .full_o   (full),
    .empty_o  (job_empty)
  );

  s5hs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign kind_o      = res.kind;
  assign out_byte_o  = res.data;
  assign dest_type_o = res.dtype;
  assign last_o      = res.last;

endmodule

// ----- rtl/core/s5hs_checker.sv -----
// ----------------------------------------------------------------------------
// s5hs_checker
// Port-level checks on the result stream of the handshake parser.
// ----------------------------------------------------------------------------
module s5hs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [1:0] dest_type_o,
  input logic       last_o
);
  import s5hs_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(out_byte_o)
                          && $stable(dest_type_o) && $stable(last_o)))
    else $error("result changed while stalled");

  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_CLOSE) |-> (last_o && out_byte_o == 8'd0))
    else $error("close not final or nonzero");

  a_dtype: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_ADDR && kind_o != KIND_PORT) |-> dest_type_o == DT_DOMAIN)
    else $error("dest_type set on non-address result");

  a_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o == KIND_CLOSE) |=> empty)
    else $error("result after close");

endmodule

bind socks5_handshake_parser_top s5hs_checker u_s5hs_checker (.*);
